[src/lgc_pkg.sv]
// Shared types and constants for the glyph block cache.
// No dependencies; imported by lgc_cell and lru_glyph_block_cache.
`default_nettype none
package lgc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 12;
  localparam int SLOT_W  = 5;

  localparam logic [IDX_W-1:0] RANK_MRU = IDX_W'(ENTRIES - 1);
  localparam logic [LEN_W-1:0] BLOCK_SIZE_RST = {LEN_W{1'b1}};

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_WRITTEN = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  // command under evaluation, broadcast to every cell
  typedef struct packed {
    logic              wr;
    logic [CODE_W-1:0] code;
  } cell_cmd_t;

  // update broadcast, valid in the cycle the command executes
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] sel_rank;
    logic [LEN_W-1:0] length;
  } cell_upd_t;

  // selected-slot data carried from cell to cell along the row
  typedef struct packed {
    logic              any;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  rank;
    logic [LEN_W-1:0]  length;
  } cell_chain_t;

endpackage
`default_nettype wire

[src/lgc_cell.sv]
// One cache slot: tag, length, valid mark and recency rank.
// Depends on lgc_pkg; instantiated in a row by lru_glyph_block_cache.
`default_nettype none
module lgc_cell
  import lgc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] idx,
  input  wire cell_cmd_t        cmd,
  input  wire cell_upd_t        upd,
  input  wire cell_chain_t      chain_in,
  output cell_chain_t           chain_out,
  output logic                  sel
);

  logic [CODE_W-1:0] tag_r;
  logic [LEN_W-1:0]  len_r;
  logic              valid_r;
  logic [IDX_W-1:0]  rank_r;
  logic              match;

  // compare tag; a write selects the least recent slot
  always_comb begin
    match = valid_r && (tag_r == cmd.code);
    sel   = cmd.wr ? (rank_r == '0) : match;
  end

  // merge this slot into the data handed to the next cell
  always_comb begin
    chain_out = chain_in;
    if (sel) begin
      chain_out.any    = 1'b1;
      chain_out.slot   = chain_in.slot | SLOT_W'(idx);
      chain_out.rank   = chain_in.rank | rank_r;
      chain_out.length = chain_in.length | len_r;
    end
  end

  // advance recency; on a write, drop older copies of the same code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= idx;
    end else if (upd.en) begin
      if (sel) begin
        rank_r <= RANK_MRU;
        if (cmd.wr) begin
          valid_r <= 1'b1;
        end
      end else begin
        if (rank_r > upd.sel_rank) begin
          rank_r <= rank_r - IDX_W'(1);
        end
        if (cmd.wr && match) begin
          valid_r <= 1'b0;
        end
      end
    end
  end

  // hold tag and length of a written slot
  always_ff @(posedge clk) begin
    if (upd.en && sel && cmd.wr) begin
      tag_r <= cmd.code;
      len_r <= upd.length;
    end
  end

endmodule
`default_nettype wire

[src/lru_glyph_block_cache.sv]
// A result is offered once its item has gone from the command register to the output
// register, or later under out_stall. No new item is taken while one is held in the
// command register; the held item makes a single update pass over the row of slot cells.
// Reset: all slots invalid, recency rank equal to slot index (slot 0 oldest),
// block size 4095. No clearing pass; the first item is taken right after reset.
// Top level of the glyph block cache; depends on lgc_pkg and lgc_cell.
`default_nettype none
module lru_glyph_block_cache
  import lgc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic [CODE_W-1:0] in_code,
  input  wire logic [LEN_W-1:0]  in_length,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [LEN_W-1:0]       out_stored_length,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [LEN_W-1:0]  cfg_block_size
);

  logic              busy_r;
  logic              act_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  block_size_r;

  logic              out_valid_r;
  status_t           status_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LEN_W-1:0]  stored_len_r;

  logic              exec;
  logic              reject;
  cell_cmd_t         cmd;
  cell_upd_t         upd;
  cell_chain_t       chain [ENTRIES+1];
  logic [ENTRIES-1:0] sel_vec;

  assign in_stall  = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_slot = slot_r;
  assign out_stored_length = stored_len_r;

  // execute when the output register is free or being emptied
  always_comb begin
    exec   = busy_r && !(out_valid_r && out_stall);
    reject = (act_r == ACT_WRITE) && (len_r > block_size_r);
    cmd.wr   = (act_r == ACT_WRITE);
    cmd.code = code_r;
    upd.en       = exec && (cmd.wr ? !reject : chain[ENTRIES].any);
    upd.sel_rank = chain[ENTRIES].rank;
    upd.length   = len_r;
  end

  assign chain[0] = '0;

  // row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lgc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(i)),
      .cmd       (cmd),
      .upd       (upd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .sel       (sel_vec[i])
    );
  end

  // hold the accepted command until it executes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      busy_r <= 1'b1;
    end else if (exec) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_r  <= in_action;
      code_r <= in_code;
      len_r  <= in_length;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      block_size_r <= cfg_block_size;
    end
  end

  // output register: load on execute, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (cmd.wr) begin
        if (reject) begin
          status_r     <= ST_REJECT;
          slot_r       <= '0;
          stored_len_r <= '0;
        end else begin
          status_r     <= ST_WRITTEN;
          slot_r       <= chain[ENTRIES].slot;
          stored_len_r <= len_r;
        end
      end else if (chain[ENTRIES].any) begin
        status_r     <= ST_HIT;
        slot_r       <= chain[ENTRIES].slot;
        stored_len_r <= chain[ENTRIES].length;
      end else begin
        status_r     <= ST_MISS;
        slot_r       <= '0;
        stored_len_r <= '0;
      end
    end
  end

  // at most one slot holds a valid copy of any code
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !cmd.wr) |-> $onehot0(sel_vec))
    else $error("several slots match one code");

  // exactly one slot is least recent
  a_victim_one: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cmd.wr) |-> $onehot(sel_vec))
    else $error("recency ranks do not hold a single oldest slot");

  // an executed command always leaves a result
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed command produced no result");

  // a result only appears after a command was pending
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result without a pending command");

endmodule
`default_nettype wire

[dv/lru_glyph_block_cache_test.sv]
// Self-checking bench for the glyph block cache: random and directed lookups and writes.
// Predicts every response with its own LRU model and compares it field by field.
// Depends on lgc_pkg and the lru_glyph_block_cache RTL.
module lru_glyph_block_cache_test;
  import lgc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 175;
  localparam int POOL_SIZE    = 40;
  localparam int IDLE_PERCENT = 38;

  typedef enum logic [1:0] {REQ_ITEM, REQ_BLOCK_SIZE, REQ_DRAIN} req_kind_t;

  typedef struct packed {
    req_kind_t         kind;
    logic              action;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic              quiet;
  } glyph_req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  stored_length;
  } glyph_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_action = ACT_LOOKUP;
  logic [CODE_W-1:0] in_code = '0;
  logic [LEN_W-1:0]  in_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [LEN_W-1:0]  out_stored_length;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_block_size = '0;

  // pending stimulus, awaited responses and the handoff between driver and monitor
  glyph_req_t  glyph_requests[$];
  glyph_resp_t awaited_responses[$];
  glyph_resp_t fresh_response;
  logic        fresh_valid = 1'b0;
  logic        quiet_r = 1'b0;

  int unsigned issued_count = 0;
  int unsigned retired_count = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  // cache model
  logic [CODE_W-1:0] line_tag   [ENTRIES];
  logic [LEN_W-1:0]  line_len   [ENTRIES];
  logic              line_valid [ENTRIES];
  int                line_rank  [ENTRIES];
  logic [LEN_W-1:0]  model_block_size;

  lru_glyph_block_cache dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_code           (in_code),
    .in_length         (in_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_stored_length (out_stored_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_block_size    (cfg_block_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at response %0d: %s", retired_count, what);
    error_count++;
  endtask

  // move a slot to the newest rank, aging everything above its old rank
  function automatic void make_newest(int s);
    int old_rank;
    old_rank = line_rank[s];
    for (int j = 0; j < ENTRIES; j++) begin
      if (line_rank[j] > old_rank) line_rank[j]--;
    end
    line_rank[s] = ENTRIES - 1;
  endfunction

  // compute the response to one request and update the cache model
  function automatic glyph_resp_t predict_cache_response(logic act, logic [CODE_W-1:0] code,
                                                         logic [LEN_W-1:0] len);
    glyph_resp_t r;
    int          pick;
    r.status = ST_MISS;
    r.slot = '0;
    r.stored_length = '0;
    pick = -1;
    if (act == ACT_LOOKUP) begin
      // newest matching valid line wins
      for (int j = 0; j < ENTRIES; j++) begin
        if (line_valid[j] && line_tag[j] == code &&
            (pick < 0 || line_rank[j] > line_rank[pick])) pick = j;
      end
      if (pick >= 0) begin
        make_newest(pick);
        r.status = ST_HIT;
        r.slot = SLOT_W'(pick);
        r.stored_length = line_len[pick];
      end
    end else if (len > model_block_size) begin
      r.status = ST_REJECT;
    end else begin
      // evict the oldest line, valid or not
      for (int j = 0; j < ENTRIES; j++) begin
        if (line_rank[j] == 0 && pick < 0) pick = j;
      end
      line_tag[pick] = code;
      line_len[pick] = len;
      line_valid[pick] = 1'b1;
      make_newest(pick);
      r.status = ST_WRITTEN;
      r.slot = SLOT_W'(pick);
      r.stored_length = len;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_write_length(logic [LEN_W-1:0] limit);
    case ($urandom_range(4))
      0: return limit;
      1: return limit + 1'b1;
      2: return '0;
      3: return LEN_W'($urandom_range(int'(limit)));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  task automatic add_request(input logic act, input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len, input logic quiet);
    glyph_req_t e;
    e.kind = REQ_ITEM;
    e.action = act;
    e.code = code;
    e.length = len;
    e.quiet = quiet;
    glyph_requests.push_back(e);
  endtask

  task automatic add_marker(input req_kind_t kind, input logic [LEN_W-1:0] value);
    glyph_req_t e;
    e = '0;
    e.kind = kind;
    e.length = value;
    glyph_requests.push_back(e);
  endtask

  // driver: one transfer in flight per channel; config and drain wait for an empty pipe
  always @(posedge clk) begin : drive_requests
    logic       next_valid;
    logic       next_cfg;
    logic       next_fresh;
    glyph_req_t e;
    next_valid = in_valid;
    next_cfg = cfg_valid;
    next_fresh = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        fresh_response <= predict_cache_response(in_action, in_code, in_length);
        next_fresh = 1'b1;
        next_valid = 1'b0;
        issued_count++;
      end
      if (cfg_valid && cfg_ready) begin
        model_block_size = cfg_block_size;
        next_cfg = 1'b0;
      end
      if (!next_valid && !next_cfg && glyph_requests.size() > 0) begin
        e = glyph_requests[0];
        case (e.kind)
          REQ_ITEM: begin
            if (e.quiet || $urandom_range(99) >= IDLE_PERCENT) begin
              void'(glyph_requests.pop_front());
              in_action <= e.action;
              in_code <= e.code;
              in_length <= e.length;
              quiet_r <= e.quiet;
              next_valid = 1'b1;
            end
          end
          REQ_BLOCK_SIZE: begin
            if (issued_count == retired_count) begin
              void'(glyph_requests.pop_front());
              cfg_block_size <= e.length;
              next_cfg = 1'b1;
            end
          end
          default: begin
            if (issued_count == retired_count) void'(glyph_requests.pop_front());
          end
        endcase
      end
    end
    in_valid <= next_valid;
    cfg_valid <= next_cfg;
    fresh_valid <= next_fresh;
  end

  // monitor: queue the prediction from the last edge, then check this edge's transfer
  always @(posedge clk) begin : check_responses
    glyph_resp_t want;
    if (fresh_valid) awaited_responses.push_back(fresh_response);
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response status %0d slot %0d length %0d",
                                  out_status, out_slot, out_stored_length));
      end else begin
        want = awaited_responses.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %s", out_status, want.status.name()));
        if (out_slot !== want.slot)
          report_mismatch($sformatf("slot %0d, want %0d", out_slot, want.slot));
        if (out_stored_length !== want.stored_length)
          report_mismatch($sformatf("stored_length %0d, want %0d",
                                    out_stored_length, want.stored_length));
        retired_count <= retired_count + 1;
      end
    end
    out_stall <= rst_n && !quiet_r && ($urandom_range(99) < IDLE_PERCENT);
  end

  // abort when no channel makes progress for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("lru_glyph_block_cache test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CODE_W-1:0] code_pool [POOL_SIZE];
    logic [LEN_W-1:0]  phase_size [PHASES];
    logic [CODE_W-1:0] pick;
    logic              quiet;

    // model reset: all lines invalid, slot 0 oldest
    for (int j = 0; j < ENTRIES; j++) begin
      line_valid[j] = 1'b0;
      line_rank[j] = j;
      line_tag[j] = '0;
      line_len[j] = '0;
    end
    model_block_size = BLOCK_SIZE_RST;

    // empty cache, field extremes, duplicate codes
    add_request(ACT_LOOKUP, 16'h0000, 12'h000, 1'b0);
    add_request(ACT_LOOKUP, 16'hFFFF, 12'hFFF, 1'b0);
    add_request(ACT_WRITE, 16'h0000, 12'h000, 1'b0);
    add_request(ACT_WRITE, 16'hFFFF, 12'hFFF, 1'b0);
    add_request(ACT_LOOKUP, 16'h0000, 12'hFFF, 1'b0);
    add_request(ACT_LOOKUP, 16'hFFFF, 12'h000, 1'b0);
    add_request(ACT_WRITE, 16'h1234, 12'd5, 1'b0);
    add_request(ACT_WRITE, 16'h1234, 12'd7, 1'b0);
    add_request(ACT_LOOKUP, 16'h1234, 12'h555, 1'b0);
    add_request(ACT_LOOKUP, 16'h1234, 12'hAAA, 1'b0);
    add_request(ACT_LOOKUP, 16'h5555, 12'h000, 1'b0);
    // zero block size: only empty writes fit
    add_marker(REQ_BLOCK_SIZE, 12'd0);
    add_request(ACT_WRITE, 16'hAAAA, 12'd0, 1'b0);
    add_request(ACT_WRITE, 16'hAAAA, 12'd1, 1'b0);
    add_request(ACT_WRITE, 16'hAAAA, 12'hFFF, 1'b0);
    add_request(ACT_LOOKUP, 16'hAAAA, 12'h000, 1'b0);
    add_marker(REQ_BLOCK_SIZE, 12'd1);
    add_request(ACT_WRITE, 16'h00FF, 12'd1, 1'b0);
    add_request(ACT_WRITE, 16'h00FF, 12'd2, 1'b0);
    add_marker(REQ_BLOCK_SIZE, 12'hFFF);
    add_request(ACT_WRITE, 16'h8000, 12'hFFF, 1'b0);
    add_request(ACT_LOOKUP, 16'h8000, 12'h000, 1'b0);

    // random phases, each under its own block size
    phase_size[0] = 12'hFFF;
    phase_size[1] = LEN_W'($urandom_range(1, 4095));
    phase_size[2] = 12'd1;
    phase_size[3] = 12'hFFF;
    phase_size[4] = 12'd0;
    phase_size[5] = LEN_W'($urandom_range(1, 4095));
    for (int k = 0; k < POOL_SIZE; k++) code_pool[k] = CODE_W'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      add_marker(REQ_BLOCK_SIZE, phase_size[p]);
      // refresh part of the working set so old codes age out
      for (int k = 0; k < 8; k++) code_pool[$urandom_range(POOL_SIZE - 1)] = CODE_W'($urandom);
      quiet = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && (p == 1 || p == 4)) add_marker(REQ_DRAIN, '0);
        if ($urandom_range(9) == 0) pick = CODE_W'($urandom);
        else pick = code_pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(1)) add_request(ACT_WRITE, pick, pick_write_length(phase_size[p]), quiet);
        else add_request(ACT_LOOKUP, pick, LEN_W'($urandom), quiet);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to go out and every response to come back
    while (glyph_requests.size() > 0 || in_valid || cfg_valid || issued_count != retired_count)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("lru_glyph_block_cache test passed");
    end else begin
      $display("lru_glyph_block_cache test failed");
    end
    $finish;
  end

endmodule
